// File: rtl/qde_pkg.sv
// Package for the quotient digit estimate block.
// Holds the default digit width and the command and status structs between controller and datapath.
// No dependencies.
package qde_pkg;

    localparam int DIGIT_BITS_DEFAULT = 30;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic fix;
    } qde_cmd_t;

    typedef struct packed {
        logic sat;
        logic r_over;
        logic fits;
    } qde_stat_t;

endpackage

// File: rtl/qde_if.sv
// Valid/ready channel interfaces for the quotient digit estimate block.
// One interface carries the input digits, the other the quotient digit; no dependencies.
interface qde_in_if #(
    parameter int DIGIT_BITS = 30
);
    logic                  valid;
    logic                  ready;
    logic [DIGIT_BITS-1:0] dividend_digit_top;
    logic [DIGIT_BITS-1:0] dividend_digit_next;
    logic [DIGIT_BITS-1:0] dividend_digit_third;
    logic [DIGIT_BITS-1:0] divisor_digit_top;
    logic [DIGIT_BITS-1:0] divisor_digit_next;

    modport source (
        output valid, dividend_digit_top, dividend_digit_next, dividend_digit_third,
               divisor_digit_top, divisor_digit_next,
        input  ready
    );
    modport sink (
        input  valid, dividend_digit_top, dividend_digit_next, dividend_digit_third,
               divisor_digit_top, divisor_digit_next,
        output ready
    );
endinterface

interface qde_out_if #(
    parameter int DIGIT_BITS = 30
);
    logic                  valid;
    logic                  ready;
    logic [DIGIT_BITS-1:0] quotient_digit;

    modport source (
        output valid, quotient_digit,
        input  ready
    );
    modport sink (
        input  valid, quotient_digit,
        output ready
    );
endinterface

// File: rtl/qde_dp.sv
// Datapath of the quotient digit estimate block: restoring divider, multiplier and correction.
// Depends on qde_pkg for the command and status structs.
module qde_dp #(
    parameter int DIGIT_BITS = qde_pkg::DIGIT_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic [DIGIT_BITS-1:0] u0,
    input  logic [DIGIT_BITS-1:0] u1,
    input  logic [DIGIT_BITS-1:0] u2,
    input  logic [DIGIT_BITS-1:0] v1,
    input  logic [DIGIT_BITS-1:0] v2,
    input  qde_pkg::qde_cmd_t     cmd,
    output qde_pkg::qde_stat_t    stat,
    output logic [DIGIT_BITS-1:0] qhat
);
    import qde_pkg::*;

    localparam int W  = DIGIT_BITS;
    localparam int PW = 2 * DIGIT_BITS;

    logic [W-1:0]  sh_reg,   sh_next;
    logic [W-1:0]  u2_reg,   u2_next;
    logic [W-1:0]  v1_reg,   v1_next;
    logic [W-1:0]  v2_reg,   v2_next;
    logic [W-1:0]  q_reg,    q_next;
    logic [W:0]    r_reg,    r_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [W:0]    trial;
    logic          ge;

    assign trial = {r_reg[W-1:0], sh_reg[W-1]};
    assign ge    = trial >= {1'b0, v1_reg};

    always_comb
    begin
        sh_next   = sh_reg;
        u2_next   = u2_reg;
        v1_next   = v1_reg;
        v2_next   = v2_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        prod_next = prod_reg;
        if (cmd.load)
        begin
            sh_next = u1;
            u2_next = u2;
            v1_next = v1;
            v2_next = v2;
            if (u0 >= v1)
            begin
                q_next = {W{1'b1}};
                r_next = {1'b0, u1} + {1'b0, v1};
            end
            else
            begin
                q_next = '0;
                r_next = {1'b0, u0};
            end
        end
        else if (cmd.div_step)
        begin
            sh_next = {sh_reg[W-2:0], 1'b0};
            q_next  = {q_reg[W-2:0], ge};
            r_next  = ge ? (trial - {1'b0, v1_reg}) : trial;
        end
        else if (cmd.mul)
        begin
            prod_next = PW'(q_reg) * PW'(v2_reg);
        end
        else if (cmd.fix)
        begin
            q_next = q_reg - W'(1);
            r_next = r_reg + {1'b0, v1_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        u2_reg   <= u2_next;
        v1_reg   <= v1_next;
        v2_reg   <= v2_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        prod_reg <= prod_next;
    end

    assign stat.sat    = u0 >= v1;
    assign stat.r_over = r_reg[W];
    assign stat.fits   = prod_reg <= {r_reg[W-1:0], u2_reg};
    assign qhat        = q_reg;

endmodule

// File: rtl/qde_ctrl.sv
// Controller of the quotient digit estimate block: sequences division and correction rounds.
// Depends on qde_pkg for the command and status structs.
module qde_ctrl #(
    parameter int DIGIT_BITS = qde_pkg::DIGIT_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  qde_pkg::qde_stat_t stat,
    output qde_pkg::qde_cmd_t  cmd
);
    import qde_pkg::*;

    localparam int CW = $clog2(DIGIT_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic          round_reg, round_next;
    logic          cnt_done;

    assign cnt_done = cnt_reg == CW'(DIGIT_BITS - 1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        round_next = round_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    round_next = 1'b0;
                    state_next = stat.sat ? ST_MUL : ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (stat.r_over)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (stat.fits)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.fix = 1'b1;
                    if (round_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        round_next = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            round_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            round_reg <= round_next;
        end
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = state_reg == ST_OUT;

    a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !cnt_done) |=> state_reg == ST_DIV)
        else $error("divider left before all quotient bits were formed");

    a_two_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && !stat.fits && round_reg) |=> state_reg == ST_OUT)
        else $error("correction ran past its second round");

    a_sat_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && stat.sat) |=> state_reg == ST_MUL)
        else $error("saturated estimate entered the divider");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.mul, cmd.fix}))
        else $error("more than one datapath command at once");

endmodule

// File: rtl/quotient_digit_estimate_top.sv
// Top level of the quotient digit estimate block: controller plus datapath.
// Depends on qde_pkg, qde_if, qde_ctrl and qde_dp.
//
// Computes the corrected trial quotient digit of long division from the three leading
// dividend digits and the two leading divisor digits, in radix 2^DIGIT_BITS. One
// transaction is worked on at a time: din is ready only when the block is idle. When the
// leading dividend digit is below the leading divisor digit, a radix-2 restoring divider
// forms one quotient bit per cycle; otherwise the estimate saturates and the divider is
// skipped. Each of at most two correction rounds is a multiply, then a compare. The next
// transaction is taken the cycle after the result leaves dout. The leading divisor digit
// must be normalized for an exact result.
module quotient_digit_estimate_top #(
    parameter int DIGIT_BITS = qde_pkg::DIGIT_BITS_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    qde_in_if.sink    din,
    qde_out_if.source dout
);
    import qde_pkg::*;

    qde_cmd_t  cmd;
    qde_stat_t stat;

    qde_ctrl #(
        .DIGIT_BITS(DIGIT_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .out_valid(dout.valid),
        .out_ready(dout.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qde_dp #(
        .DIGIT_BITS(DIGIT_BITS)
    ) u_dp (
        .clk (clk),
        .u0  (din.dividend_digit_top),
        .u1  (din.dividend_digit_next),
        .u2  (din.dividend_digit_third),
        .v1  (din.divisor_digit_top),
        .v2  (din.divisor_digit_next),
        .cmd (cmd),
        .stat(stat),
        .qhat(dout.quotient_digit)
    );

endmodule

// File: dv/quotient_digit_estimate_top_tb.sv
// Testbench for quotient_digit_estimate_top: directed and random digit sets on din, results
// on dout checked against a built-in model of the trial quotient digit and its correction.
// Depends on qde_pkg, qde_if and the RTL of the block.
module quotient_digit_estimate_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGIT_BITS = qde_pkg::DIGIT_BITS_DEFAULT;
    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * DIGIT_BITS + 20;

    localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = '1;
    localparam logic [DIGIT_BITS-1:0] DIGIT_HALF = {1'b1, {(DIGIT_BITS-1){1'b0}}};
    localparam logic [DIGIT_BITS-1:0] DIGIT_ALT_A = DIGIT_MAX / 3;
    localparam logic [DIGIT_BITS-1:0] DIGIT_ALT_B = DIGIT_MAX ^ DIGIT_ALT_A;

    typedef struct packed {
        logic [DIGIT_BITS-1:0] u0;
        logic [DIGIT_BITS-1:0] u1;
        logic [DIGIT_BITS-1:0] u2;
        logic [DIGIT_BITS-1:0] v1;
        logic [DIGIT_BITS-1:0] v2;
    } digit_set_t;

    logic clk = 1'b0;
    logic rst_n;

    qde_in_if #(.DIGIT_BITS(DIGIT_BITS)) din_if ();
    qde_out_if #(.DIGIT_BITS(DIGIT_BITS)) dout_if ();

    quotient_digit_estimate_top #(
        .DIGIT_BITS(DIGIT_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if.sink),
        .dout  (dout_if.source)
    );

    digit_set_t                  pending_digits[$];
    logic [DIGIT_BITS-1:0]       quotient_expected[$];
    int unsigned                 total_items;
    int unsigned                 accepted_cnt;
    int unsigned                 checked_cnt;
    int unsigned                 error_cnt;
    int unsigned                 saturated_cnt;
    int unsigned                 one_fix_cnt;
    int unsigned                 two_fix_cnt;
    int unsigned                 gap_left;
    int unsigned                 burst_left;
    int unsigned                 quiet_cycles;
    logic [15:0]                 stall_word;
    logic [15:0]                 stall_tick;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [DIGIT_BITS-1:0] estimate_qhat(input digit_set_t d,
                                                           output int unsigned fixes,
                                                           output logic saturated);
        logic [63:0] radix;
        logic [63:0] u0;
        logic [63:0] u1;
        logic [63:0] u2;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] num;
        logic [63:0] qhat;
        logic [63:0] rhat;
        logic        settled;
        int          k;
        radix = 64'd1 << DIGIT_BITS;
        u0 = 64'(d.u0);
        u1 = 64'(d.u1);
        u2 = 64'(d.u2);
        v1 = 64'(d.v1);
        v2 = 64'(d.v2);
        fixes = 0;
        saturated = (u0 >= v1);
        if (saturated)
        begin
            qhat = radix - 1;
            rhat = u1 + v1;
        end
        else
        begin
            num = (u0 << DIGIT_BITS) | u1;
            qhat = num / v1;
            rhat = num % v1;
        end
        settled = 1'b0;
        for (k = 0; k < 2; k++)
        begin
            if (!settled)
            begin
                if (rhat >= radix || qhat * v2 <= ((rhat << DIGIT_BITS) | u2))
                begin
                    settled = 1'b1;
                end
                else
                begin
                    qhat = qhat - 1;
                    rhat = rhat + v1;
                    fixes++;
                end
            end
        end
        return qhat[DIGIT_BITS-1:0];
    endfunction

    function automatic logic [DIGIT_BITS-1:0] rand_digit();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DIGIT_MAX;
            default: return DIGIT_BITS'($urandom);
        endcase
    endfunction

    function automatic digit_set_t make_digits();
        digit_set_t  d;
        logic [63:0] span;
        int unsigned pick;
        d.u1 = rand_digit();
        d.u2 = rand_digit();
        d.v2 = rand_digit();
        pick = $urandom_range(0, 99);
        if (pick < 88)
            d.v1 = DIGIT_HALF | DIGIT_BITS'($urandom);
        else if (pick < 97)
            d.v1 = DIGIT_BITS'($urandom);
        else
            d.v1 = DIGIT_BITS'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 35 && d.v1 != '0)
        begin
            d.u0 = DIGIT_BITS'({$urandom, $urandom} % 64'(d.v1));
        end
        else if (pick < 60 && d.v1 > DIGIT_BITS'(3))
        begin
            d.u0 = d.v1 - DIGIT_BITS'($urandom_range(1, 3));
        end
        else if (pick < 75)
        begin
            d.u0 = d.v1;
        end
        else if (pick < 85 && d.v1 != DIGIT_MAX)
        begin
            span = 64'(DIGIT_MAX) - 64'(d.v1);
            d.u0 = DIGIT_BITS'(64'(d.v1) + 64'd1 + ({$urandom, $urandom} % span));
        end
        else
        begin
            d.u0 = rand_digit();
        end
        return d;
    endfunction

    task automatic add_digits(input logic [DIGIT_BITS-1:0] u0, input logic [DIGIT_BITS-1:0] u1,
                              input logic [DIGIT_BITS-1:0] u2, input logic [DIGIT_BITS-1:0] v1,
                              input logic [DIGIT_BITS-1:0] v2);
        digit_set_t d;
        d.u0 = u0;
        d.u1 = u1;
        d.u2 = u2;
        d.v1 = v1;
        d.v2 = v2;
        pending_digits.push_back(d);
    endtask

    // Sender: presents queued digit sets in bursts separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned fixes;
        logic        saturated;
        digit_set_t  d;
        if (!rst_n)
        begin
            din_if.valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 1;
        end
        else
        begin
            if (din_if.valid && din_if.ready)
            begin
                d.u0 = din_if.dividend_digit_top;
                d.u1 = din_if.dividend_digit_next;
                d.u2 = din_if.dividend_digit_third;
                d.v1 = din_if.divisor_digit_top;
                d.v2 = din_if.divisor_digit_next;
                quotient_expected.push_back(estimate_qhat(d, fixes, saturated));
                accepted_cnt++;
                if (saturated)
                    saturated_cnt++;
                if (fixes == 1)
                    one_fix_cnt++;
                if (fixes == 2)
                    two_fix_cnt++;
            end
            if (!din_if.valid || din_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    din_if.valid <= 1'b0;
                end
                else if (pending_digits.size() > 0)
                begin
                    d = pending_digits.pop_front();
                    din_if.valid <= 1'b1;
                    din_if.dividend_digit_top <= d.u0;
                    din_if.dividend_digit_next <= d.u1;
                    din_if.dividend_digit_third <= d.u2;
                    din_if.divisor_digit_top <= d.v1;
                    din_if.divisor_digit_next <= d.v2;
                    if (burst_left <= 1)
                    begin
                        burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                                   : $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 45);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    din_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls on a pattern reloaded on a tick counter and checks each transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_if.ready <= 1'b0;
            stall_tick <= '0;
            stall_word <= '1;
        end
        else
        begin
            if (stall_tick[5:0] == 6'd0)
                stall_word <= ($urandom_range(0, 9) < 3) ? 16'hffff
                                                         : (16'($urandom) | 16'h0101);
            stall_tick <= stall_tick + 1'b1;
            dout_if.ready <= stall_word[stall_tick[3:0]];
            if (dout_if.valid && dout_if.ready)
            begin
                if (quotient_expected.size() == 0)
                begin
                    error_cnt++;
                    if (error_cnt <= 10)
                        $display("ERROR: unexpected quotient digit 0x%0h", dout_if.quotient_digit);
                end
                else
                begin
                    checked_cnt++;
                    if (dout_if.quotient_digit !== quotient_expected[0])
                    begin
                        error_cnt++;
                        if (error_cnt <= 10)
                            $display("ERROR: quotient digit expected 0x%0h actual 0x%0h",
                                     quotient_expected[0], dout_if.quotient_digit);
                    end
                    void'(quotient_expected.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
                $display("quotient_digit_estimate_top test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        din_if.valid = 1'b0;
        din_if.dividend_digit_top = '0;
        din_if.dividend_digit_next = '0;
        din_if.dividend_digit_third = '0;
        din_if.divisor_digit_top = '0;
        din_if.divisor_digit_next = '0;
        dout_if.ready = 1'b0;
        accepted_cnt = 0;
        checked_cnt = 0;
        error_cnt = 0;
        saturated_cnt = 0;
        one_fix_cnt = 0;
        two_fix_cnt = 0;
        quiet_cycles = 0;

        add_digits('0, '0, '0, DIGIT_HALF, '0);
        add_digits(DIGIT_HALF - 1'b1, DIGIT_MAX, DIGIT_MAX, DIGIT_HALF, '0);
        add_digits(DIGIT_MAX, DIGIT_MAX, DIGIT_MAX, DIGIT_MAX, DIGIT_MAX);
        add_digits(DIGIT_HALF, '0, '0, DIGIT_HALF, DIGIT_MAX);
        add_digits(DIGIT_MAX, '0, '0, DIGIT_HALF, DIGIT_MAX);
        add_digits('0, DIGIT_BITS'(5), '0, '0, DIGIT_MAX);
        add_digits(DIGIT_MAX, DIGIT_MAX, DIGIT_MAX, '0, '0);
        add_digits(DIGIT_HALF - 1'b1, '0, '0, DIGIT_HALF, DIGIT_MAX);
        add_digits(DIGIT_HALF - 1'b1, '0, '0, DIGIT_HALF, DIGIT_BITS'(1));
        add_digits('0, DIGIT_MAX, DIGIT_MAX, DIGIT_BITS'(1), DIGIT_MAX);
        add_digits(DIGIT_MAX - 2'd2, DIGIT_MAX, '0, DIGIT_MAX - 1'b1, DIGIT_MAX);
        add_digits(DIGIT_MAX - 1'b1, DIGIT_MAX, DIGIT_MAX, DIGIT_MAX, DIGIT_MAX);
        add_digits(DIGIT_ALT_A, DIGIT_ALT_B, DIGIT_ALT_A, DIGIT_ALT_B, DIGIT_ALT_B);
        add_digits(DIGIT_ALT_B, DIGIT_ALT_A, DIGIT_ALT_B, DIGIT_ALT_B, DIGIT_ALT_A);
        add_digits(DIGIT_ALT_A, DIGIT_ALT_A, DIGIT_ALT_B, DIGIT_ALT_A, DIGIT_ALT_B);
        add_digits('0, DIGIT_MAX, '0, DIGIT_HALF, DIGIT_MAX);
        for (n = 0; n < RANDOM_ITEMS; n++)
            pending_digits.push_back(make_digits());
        total_items = pending_digits.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < total_items || quotient_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d quotient digits: %0d saturated estimates, %0d with one correction,",
                 checked_cnt, saturated_cnt, one_fix_cnt);
        $display("%0d with two corrections; %0d failures.", two_fix_cnt, error_cnt);
        if (error_cnt == 0)
            $display("quotient_digit_estimate_top test passed");
        else
            $display("quotient_digit_estimate_top test failed");
        $finish;
    end

endmodule
